// ----- rtl/assert_macros.svh -----
// Assertion shorthands used by the top-level median module.
// Both expect signals named clk and rst_n in the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SWM_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SWM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/swm_pkg.sv -----
package swm_pkg;

    // Frame geometry
    localparam int WINDOW_DEPTH = 1024;
    localparam int VALUE_BITS   = 64;
    localparam int FIELD_BITS   = 64;

    // Each sorted chain holds one half of the frame, plus one entry of slack
    // for the moment between an insert and the rebalance step.
    localparam int CHAIN_DEPTH  = WINDOW_DEPTH / 2 + 1;
    localparam int CNT_W        = $clog2(CHAIN_DEPTH + 1);
    localparam int LEN_W        = $clog2(WINDOW_DEPTH + 1);
    localparam int PTR_W        = $clog2(WINDOW_DEPTH);

    typedef logic signed [VALUE_BITS-1:0] value_t;
    typedef logic signed [VALUE_BITS:0]   wide_t;

    // Minus and plus infinity
    localparam value_t VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam value_t VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // Commands
    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    // Result status
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_REFUSED = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;
    localparam logic [1:0] STAT_RANGE   = 2'd3;

    // Operation broadcast to every cell of a chain
    typedef enum logic [2:0] {
        CH_NOP,
        CH_INSERT,
        CH_DELETE,
        CH_POP,
        CH_CLEAR
    } chain_op_t;

    typedef struct packed {
        chain_op_t op;
        value_t    key;
    } chain_ctrl_t;

    // Contents of one cell as seen by its neighbors
    typedef struct packed {
        value_t val;
        logic   valid;
    } cell_data_t;

endpackage

// ----- rtl/swm_ram.sv -----
module swm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/swm_cell.sv -----
module swm_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  swm_pkg::chain_ctrl_t ctrl,
    input  swm_pkg::cell_data_t prev_data,
    input  logic                prev_stays,
    input  swm_pkg::cell_data_t next_data,
    output swm_pkg::cell_data_t data,
    output logic                stays
);

    import swm_pkg::*;

    value_t val_reg;
    value_t val_next;
    logic   valid_reg;
    logic   valid_next;
    logic   above_key;

    // Rank this entry against the broadcast key; the chain is sorted
    // descending, so an entry that stays sits ahead of the key.
    always_comb
    begin
        stays     = valid_reg && (val_reg >= ctrl.key);
        above_key = valid_reg && (val_reg > ctrl.key);
    end

    // Pick the next contents: hold, take the key, or take a neighbor's entry
    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        case (ctrl.op)
            CH_INSERT:
            begin
                if (!stays)
                begin
                    if (prev_stays)
                    begin
                        val_next   = ctrl.key;
                        valid_next = 1'b1;
                    end
                    else
                    begin
                        val_next   = prev_data.val;
                        valid_next = prev_data.valid;
                    end
                end
            end
            CH_DELETE:
            begin
                if (!above_key)
                begin
                    val_next   = next_data.val;
                    valid_next = next_data.valid;
                end
            end
            CH_POP:
            begin
                val_next   = next_data.val;
                valid_next = next_data.valid;
            end
            CH_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                val_next   = val_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // Occupancy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Stored value
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign data.val   = val_reg;
    assign data.valid = valid_reg;

endmodule

// ----- rtl/swm_chain.sv -----
module swm_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  swm_pkg::chain_ctrl_t ctrl,
    output swm_pkg::cell_data_t  top
);

    import swm_pkg::*;

    cell_data_t data_w  [CHAIN_DEPTH];
    logic       stays_w [CHAIN_DEPTH-1];

    // Row of cells, each sorted against its neighbors; cell 0 holds the top
    for (genvar i = 0; i < CHAIN_DEPTH; i++)
    begin : g_cell
        cell_data_t prev_d;
        cell_data_t next_d;
        logic       prev_s;

        if (i == 0)
        begin : g_head
            assign prev_d = '0;
            assign prev_s = 1'b1;
        end
        else
        begin : g_body
            assign prev_d = data_w[i-1];
            assign prev_s = stays_w[i-1];
        end

        if (i == CHAIN_DEPTH - 1)
        begin : g_tail
            assign next_d = '0;
            swm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_data  (prev_d),
                .prev_stays (prev_s),
                .next_data  (next_d),
                .data       (data_w[i]),
                .stays      ()
            );
        end
        else
        begin : g_link
            assign next_d = data_w[i+1];
            swm_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .prev_data  (prev_d),
                .prev_stays (prev_s),
                .next_data  (next_d),
                .data       (data_w[i]),
                .stays      (stays_w[i])
            );
        end
    end

    assign top = data_w[0];

endmodule

// ----- rtl/sliding_window_median_two_heaps.sv -----
// Moving-frame median over up to WINDOW_DEPTH signed values. The frame is kept
// as two sorted chains of cells: the lower half descending and the upper half
// stored complemented, so both tops sit in cell 0 and are read without a search.
// Arrival order lives in a ring RAM that is checked on remove. Clear, null,
// refused or dropped items pass through accept, execute, median and deliver
// steps; a successful add or remove also takes the rebalance shift step between
// execute and median. Every chain update is a shift of all cells at once, and
// the halfway median uses 65-bit arithmetic for the rounded half gap. A result that is
// not taken holds the block in its deliver step. Reset empties both chains at
// once; no clearing pass is needed.
`include "assert_macros.svh"

module sliding_window_median_two_heaps (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          cmd,
    input  logic signed [swm_pkg::FIELD_BITS-1:0] value,
    input  logic                                value_is_null,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [swm_pkg::FIELD_BITS-1:0] median,
    output logic                                median_valid,
    output logic [1:0]                          status
);

    import swm_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_BAL,
        S_MED,
        S_FIN
    } state_t;

    typedef enum logic [1:0] {
        M_NONE,
        M_LO,
        M_HI,
        M_MID
    } med_mode_t;

    state_t            state_reg, state_next;
    logic [1:0]        cmd_reg, cmd_next;
    value_t            val_reg, val_next;
    logic              null_reg, null_next;
    logic [CNT_W-1:0]  nl_reg, nl_next;
    logic [CNT_W-1:0]  nu_reg, nu_next;
    logic [PTR_W-1:0]  head_reg, head_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [1:0]        stat_reg, stat_next;
    med_mode_t         mode_reg, mode_next;
    value_t            half_reg, half_next;
    logic              out_valid_reg, out_valid_next;
    value_t            out_med_reg, out_med_next;
    logic              out_mvalid_reg, out_mvalid_next;
    logic [1:0]        out_stat_reg, out_stat_next;

    chain_ctrl_t       lower_ctrl;
    chain_ctrl_t       upper_ctrl;
    cell_data_t        lower_top;
    cell_data_t        upper_top;
    value_t            lo;
    value_t            hi;

    logic              ram_we;
    logic [PTR_W-1:0]  slot_ptr;
    value_t            ram_rdata;
    logic [LEN_W:0]    ptr_sum;
    wide_t             span;

    // Lower half, descending
    swm_chain u_lower (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (lower_ctrl),
        .top   (lower_top)
    );

    // Upper half, stored complemented so it sorts descending as well
    swm_chain u_upper (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (upper_ctrl),
        .top   (upper_top)
    );

    // Arrival-order ring; the read port always watches the oldest slot
    swm_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot_ptr),
        .wdata (val_reg),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign lo = lower_top.val;
    assign hi = ~upper_top.val;

    // Slot behind the newest entry, wrapped
    always_comb
    begin
        ptr_sum = (LEN_W+1)'(head_reg) + (LEN_W+1)'(len_reg);
        if (ptr_sum >= (LEN_W+1)'(WINDOW_DEPTH))
        begin
            ptr_sum = ptr_sum - (LEN_W+1)'(WINDOW_DEPTH);
        end
        slot_ptr = PTR_W'(ptr_sum);
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        val_next        = val_reg;
        null_next       = null_reg;
        nl_next         = nl_reg;
        nu_next         = nu_reg;
        head_next       = head_reg;
        len_next        = len_reg;
        stat_next       = stat_reg;
        mode_next       = mode_reg;
        half_next       = half_reg;
        out_valid_next  = out_valid_reg;
        out_med_next    = out_med_reg;
        out_mvalid_next = out_mvalid_reg;
        out_stat_next   = out_stat_reg;
        lower_ctrl.op   = CH_NOP;
        lower_ctrl.key  = val_reg;
        upper_ctrl.op   = CH_NOP;
        upper_ctrl.key  = ~val_reg;
        ram_we          = 1'b0;
        span            = (wide_t'(hi) - wide_t'(lo) + wide_t'(1)) >> 1;

        // Drop the result once it is taken
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next   = cmd;
                    val_next   = value_t'(value[VALUE_BITS-1:0]);
                    null_next  = value_is_null;
                    state_next = S_EXEC;
                end
            end

            S_EXEC:
            begin
                stat_next  = STAT_OK;
                state_next = S_MED;
                if (!null_reg && cmd_reg == CMD_ADD)
                begin
                    if (len_reg >= LEN_W'(WINDOW_DEPTH))
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        ram_we     = 1'b1;
                        len_next   = len_reg + LEN_W'(1);
                        state_next = S_BAL;
                        if (nl_reg == '0 || val_reg <= lo)
                        begin
                            lower_ctrl.op = CH_INSERT;
                            nl_next       = nl_reg + CNT_W'(1);
                        end
                        else
                        begin
                            upper_ctrl.op = CH_INSERT;
                            nu_next       = nu_reg + CNT_W'(1);
                        end
                    end
                end
                else if (!null_reg && cmd_reg == CMD_REMOVE)
                begin
                    if (len_reg == '0 || ram_rdata != val_reg)
                    begin
                        stat_next = STAT_REFUSED;
                    end
                    else
                    begin
                        head_next  = (head_reg == PTR_W'(WINDOW_DEPTH - 1)) ?
                                     '0 : head_reg + PTR_W'(1);
                        len_next   = len_reg - LEN_W'(1);
                        state_next = S_BAL;
                        if (nl_reg != '0 && val_reg <= lo)
                        begin
                            lower_ctrl.op = CH_DELETE;
                            nl_next       = nl_reg - CNT_W'(1);
                        end
                        else
                        begin
                            upper_ctrl.op = CH_DELETE;
                            nu_next       = nu_reg - CNT_W'(1);
                        end
                    end
                end
                else if (cmd_reg == CMD_CLEAR)
                begin
                    lower_ctrl.op = CH_CLEAR;
                    upper_ctrl.op = CH_CLEAR;
                    nl_next       = '0;
                    nu_next       = '0;
                    head_next     = '0;
                    len_next      = '0;
                end
            end

            S_BAL:
            begin
                // Move one top across so the lower half holds equal or one more
                state_next = S_MED;
                if ({1'b0, nl_reg} > ({1'b0, nu_reg} + (CNT_W+1)'(1)))
                begin
                    lower_ctrl.op  = CH_POP;
                    upper_ctrl.op  = CH_INSERT;
                    upper_ctrl.key = ~lo;
                    nl_next        = nl_reg - CNT_W'(1);
                    nu_next        = nu_reg + CNT_W'(1);
                end
                else if (nu_reg > nl_reg)
                begin
                    upper_ctrl.op  = CH_POP;
                    lower_ctrl.op  = CH_INSERT;
                    lower_ctrl.key = hi;
                    nu_next        = nu_reg - CNT_W'(1);
                    nl_next        = nl_reg + CNT_W'(1);
                end
            end

            S_MED:
            begin
                // Classify the median and precompute the rounded half gap
                state_next = S_FIN;
                half_next  = value_t'(span[VALUE_BITS-1:0]);
                if (nl_reg == '0)
                begin
                    mode_next = M_NONE;
                end
                else if (nl_reg > nu_reg || lo == hi)
                begin
                    mode_next = M_LO;
                end
                else if (lo == VALUE_MIN && hi == VALUE_MAX)
                begin
                    mode_next = M_NONE;
                    if (stat_reg == STAT_OK)
                    begin
                        stat_next = STAT_RANGE;
                    end
                end
                else if (lo == VALUE_MIN)
                begin
                    mode_next = M_LO;
                end
                else if (hi == VALUE_MAX)
                begin
                    mode_next = M_HI;
                end
                else
                begin
                    mode_next = M_MID;
                end
            end

            S_FIN:
            begin
                // Load the output beat once the slot is free
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_stat_next  = stat_reg;
                    state_next     = S_IDLE;
                    case (mode_reg)
                        M_LO:
                        begin
                            out_med_next    = lo;
                            out_mvalid_next = 1'b1;
                        end
                        M_HI:
                        begin
                            out_med_next    = hi;
                            out_mvalid_next = 1'b1;
                        end
                        M_MID:
                        begin
                            out_med_next    = lo + half_reg;
                            out_mvalid_next = 1'b1;
                        end
                        default:
                        begin
                            out_med_next    = '0;
                            out_mvalid_next = 1'b0;
                        end
                    endcase
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= CMD_ADD;
            val_reg        <= '0;
            null_reg       <= 1'b0;
            nl_reg         <= '0;
            nu_reg         <= '0;
            head_reg       <= '0;
            len_reg        <= '0;
            stat_reg       <= STAT_OK;
            mode_reg       <= M_NONE;
            half_reg       <= '0;
            out_valid_reg  <= 1'b0;
            out_med_reg    <= '0;
            out_mvalid_reg <= 1'b0;
            out_stat_reg   <= STAT_OK;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            val_reg        <= val_next;
            null_reg       <= null_next;
            nl_reg         <= nl_next;
            nu_reg         <= nu_next;
            head_reg       <= head_next;
            len_reg        <= len_next;
            stat_reg       <= stat_next;
            mode_reg       <= mode_next;
            half_reg       <= half_next;
            out_valid_reg  <= out_valid_next;
            out_med_reg    <= out_med_next;
            out_mvalid_reg <= out_mvalid_next;
            out_stat_reg   <= out_stat_next;
        end
    end

    assign in_stall     = (state_reg != S_IDLE);
    assign out_valid    = out_valid_reg;
    assign median       = FIELD_BITS'(out_med_reg);
    assign median_valid = out_mvalid_reg;
    assign status       = out_stat_reg;

    `SWM_ASSERT_NEXT(a_balanced, state_reg == S_BAL, (nl_reg == nu_reg) || (nl_reg == (nu_reg + CNT_W'(1))), "halves unbalanced after rebalance")
    `SWM_ASSERT_HOLDS(a_len_match, state_reg == S_IDLE, (LEN_W+1)'(len_reg) == ((LEN_W+1)'(nl_reg) + (LEN_W+1)'(nu_reg)), "ring length differs from chain counts")
    `SWM_ASSERT_HOLDS(a_top_valid, state_reg == S_IDLE, lower_top.valid == (nl_reg != '0), "lower top occupancy differs from count")
    `SWM_ASSERT_HOLDS(a_halves_ordered, (state_reg == S_IDLE) && (nu_reg != '0), upper_top.valid && (lo <= hi), "lower top above upper top")

endmodule
